FILE: hw/rtl/bbd_pkg.sv
// Shared types and constants for the Bernstein basis evaluator.
// Holds the binomial table, the back-end state type and queue status.
// No dependencies.
package bbd_pkg;

  localparam int MAX_DEGREE_DEF = 8;
  localparam int FRAC_BITS_DEF  = 16;

  // Degree and index fields are 4 bits wide.
  localparam int IDX_W = 4;
  localparam logic [IDX_W-1:0] DEGREE_RESET = 4'd3;

  // Binomial table covers every degree a 4-bit field can hold.
  localparam int BIN_N = 16;
  localparam int BIN_W = 13;  // C(15,7) = 6435

  typedef logic [BIN_W-1:0] binom_t;
  typedef binom_t [BIN_N-1:0][BIN_N-1:0] binom_tab_t;

  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int m = 0; m < BIN_N; m++) begin
      for (int k = 0; k <= m; k++) begin
        if (k == 0 || k == m) begin
          tab[m][k] = binom_t'(1);
        end else begin
          tab[m][k] = tab[m-1][k-1] + tab[m-1][k];
        end
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM = build_binom();

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POWER,
    BK_ISSUE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: hw/rtl/bbd_queue.sv
// Two-entry request queue between front end and back end.
// Depends on bbd_pkg (q_stat_t).
module bbd_queue #(
  parameter int W = 21
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  logic [W-1:0]    wdata,
  input  logic            pop,
  output logic [W-1:0]    rdata,
  output bbd_pkg::q_stat_t stat
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (!push && pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

endmodule

FILE: hw/rtl/bbd_front.sv
// Front end: takes requests, saturates point and degree, feeds the queue.
// Depends on bbd_pkg (IDX_W, q_stat_t).
module bbd_front #(
  parameter int MAX_DEGREE = bbd_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bbd_pkg::FRAC_BITS_DEF
) (
  input  logic                               start,
  output logic                               busy,
  input  logic [FRAC_BITS:0]                 xi,
  input  logic [bbd_pkg::IDX_W-1:0]          degree,
  input  bbd_pkg::q_stat_t                   stat,
  output logic                               push,
  output logic [bbd_pkg::IDX_W+FRAC_BITS:0]  item
);

  localparam int XW = FRAC_BITS + 1;
  localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;
  localparam logic [bbd_pkg::IDX_W-1:0] DEG_MAX = bbd_pkg::IDX_W'(MAX_DEGREE);

  logic [XW-1:0]             x_sat;
  logic [bbd_pkg::IDX_W-1:0] deg_sat;

  always_comb begin
    x_sat   = (xi > ONE) ? ONE : xi;
    deg_sat = (degree > DEG_MAX) ? DEG_MAX : degree;
  end

  assign busy = stat.full;
  assign push = start && !stat.full;
  assign item = {deg_sat, x_sat};

endmodule

FILE: hw/rtl/bbd_back.sv
// Back end: power sweep of (1-x), then one basis index per cycle through
// a four-stage pipeline (products, binomial scale, derivatives, clamp).
// Depends on bbd_pkg (BINOM, back_state_t, q_stat_t).
module bbd_back #(
  parameter int MAX_DEGREE = bbd_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bbd_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  bbd_pkg::q_stat_t                                 stat,
  input  logic [bbd_pkg::IDX_W+FRAC_BITS:0]                item,
  output logic                                             pop,
  output logic                                             strobe,
  output logic [bbd_pkg::IDX_W-1:0]                        basis_index,
  output logic [FRAC_BITS:0]                               basis_value,
  output logic signed [FRAC_BITS+$clog2(MAX_DEGREE+1):0]   first_derivative,
  output logic signed [FRAC_BITS+$clog2(2*MAX_DEGREE*(MAX_DEGREE-1)+1):0]
                                                           second_derivative,
  output logic                                             last
);

  localparam int IW   = bbd_pkg::IDX_W;
  localparam int XW   = FRAC_BITS + 1;
  localparam int PW   = 2 * XW;
  localparam int TW   = XW + bbd_pkg::BIN_W;
  localparam int D1W  = FRAC_BITS + $clog2(MAX_DEGREE + 1) + 1;
  localparam int D2W  = FRAC_BITS + $clog2(2 * MAX_DEGREE * (MAX_DEGREE - 1) + 1) + 1;
  localparam int D1RW = TW + 6;
  localparam int S2W  = TW + 3;
  localparam int D2RW = S2W + 9;
  localparam int QN   = (MAX_DEGREE + 1 < 3) ? 3 : MAX_DEGREE + 1;
  localparam int QAW  = $clog2(QN);

  localparam logic [XW-1:0] ONE  = XW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [D1RW-1:0] D1_HI = D1RW'(MAX_DEGREE) << FRAC_BITS;
  localparam logic signed [D1RW-1:0] D1_LO = -D1_HI;
  localparam logic signed [D2RW-1:0] D2_HI =
    D2RW'(2 * MAX_DEGREE * (MAX_DEGREE - 1)) << FRAC_BITS;
  localparam logic signed [D2RW-1:0] D2_LO = -D2_HI;

  // rounded fixed-point product, half rounds up
  function automatic logic [XW-1:0] rmul(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(b) + HALF;
    return p[FRAC_BITS +: XW];
  endfunction

  bbd_pkg::back_state_t state, state_next;
  logic powering, issuing;

  logic [XW-1:0] x_r, y_r, pw_p, qpow;
  logic [IW-1:0] deg_r, cnt, idx;
  logic [IW-1:0] qaddr;
  logic [XW-1:0] qs [QN];

  // stage 1: rounded products
  logic          s1_valid, s1_last;
  logic [IW-1:0] s1_idx, s1_deg;
  logic [XW-1:0] s1_r0, s1_r1, s1_r2;

  // stage 2: binomial-scaled terms and history
  logic          s2_valid, s2_last;
  logic [IW-1:0] s2_idx, s2_deg;
  logic [7:0]    s2_dd;
  logic [TW-1:0] s2_t0, s2_t1c, s2_t1p, s2_t2c, s2_t2p, s2_t2pp;
  logic [TW-1:0] h_t1, h_t2, h_t2b;
  logic [TW-1:0] t0, t1, t2;
  logic          t1_ok, t2_ok;

  // stage 3: raw derivatives
  logic                   s3_valid, s3_last;
  logic [IW-1:0]          s3_idx;
  logic [XW-1:0]          s3_val;
  logic signed [D1RW-1:0] s3_d1;
  logic signed [D2RW-1:0] s3_d2;
  logic signed [TW:0]     diff1;
  logic signed [S2W-1:0]  sum2;
  logic signed [D1RW-1:0] d1_raw, d1_cl;
  logic signed [D2RW-1:0] d2_raw, d2_cl;

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    case (state)
      bbd_pkg::BK_IDLE: begin
        if (!stat.empty) state_next = bbd_pkg::BK_POWER;
      end
      bbd_pkg::BK_POWER: begin
        if (cnt == deg_r) state_next = bbd_pkg::BK_ISSUE;
      end
      bbd_pkg::BK_ISSUE: begin
        if (idx == deg_r) state_next = bbd_pkg::BK_IDLE;
      end
      default: state_next = bbd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    powering = 1'b0;
    issuing  = 1'b0;
    case (state)
      bbd_pkg::BK_IDLE:  pop      = !stat.empty;
      bbd_pkg::BK_POWER: powering = 1'b1;
      bbd_pkg::BK_ISSUE: issuing  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bbd_pkg::BK_IDLE;
      cnt      <= '0;
      idx      <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issuing;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      strobe   <= s3_valid;
      if (pop) begin
        cnt <= '0;
        idx <= '0;
      end else if (powering) begin
        cnt <= cnt + 1'b1;
      end else if (issuing) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // ---------------- power sweep / issue ----------------
  assign qaddr = deg_r - cnt;

  always_ff @(posedge clk) begin
    if (pop) begin
      x_r   <= item[XW-1:0];
      y_r   <= ONE - item[XW-1:0];
      deg_r <= item[XW +: IW];
      pw_p  <= ONE;
      qpow  <= ONE;
    end else if (powering) begin
      qpow <= rmul(qpow, y_r);
    end else if (issuing) begin
      pw_p <= rmul(pw_p, x_r);
    end
  end

  // qs[j] holds Q[d-i-j] while issuing index i
  always_ff @(posedge clk) begin
    if (powering) begin
      qs[qaddr[QAW-1:0]] <= qpow;
    end else if (issuing) begin
      for (int j = 0; j < QN - 1; j++) begin
        qs[j] <= qs[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      s1_idx  <= idx;
      s1_deg  <= deg_r;
      s1_last <= (idx == deg_r);
      s1_r0   <= rmul(pw_p, qs[0]);
      s1_r1   <= rmul(pw_p, qs[1]);
      s1_r2   <= rmul(pw_p, qs[2]);
    end
  end

  // ---------------- stage 2 ----------------
  always_comb begin
    t1_ok = (s1_idx < s1_deg);
    t2_ok = ({1'b0, s1_idx} + 5'd2) <= {1'b0, s1_deg};
    t0 = TW'(bbd_pkg::BINOM[s1_deg][s1_idx]) * TW'(s1_r0);
    t1 = t1_ok ? TW'(bbd_pkg::BINOM[s1_deg - 4'd1][s1_idx]) * TW'(s1_r1) : '0;
    t2 = t2_ok ? TW'(bbd_pkg::BINOM[s1_deg - 4'd2][s1_idx]) * TW'(s1_r2) : '0;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_idx  <= s1_idx;
      s2_deg  <= s1_deg;
      s2_last <= s1_last;
      s2_dd   <= 8'(s1_deg) * 8'(s1_deg - 4'd1);
      s2_t0   <= t0;
      s2_t1c  <= t1;
      s2_t2c  <= t2;
      s2_t1p  <= (s1_idx == '0) ? '0 : h_t1;
      s2_t2p  <= (s1_idx == '0) ? '0 : h_t2;
      s2_t2pp <= (s1_idx < 4'd2) ? '0 : h_t2b;
      h_t1    <= t1;
      h_t2    <= t2;
      h_t2b   <= h_t2;
    end
  end

  // ---------------- stage 3 ----------------
  always_comb begin
    diff1  = $signed({1'b0, s2_t1p}) - $signed({1'b0, s2_t1c});
    sum2   = $signed({3'b000, s2_t2pp}) - $signed({2'b00, s2_t2p, 1'b0})
           + $signed({3'b000, s2_t2c});
    d1_raw = D1RW'(diff1) * D1RW'($signed({1'b0, s2_deg}));
    d2_raw = D2RW'(sum2) * D2RW'($signed({1'b0, s2_dd}));
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      s3_idx  <= s2_idx;
      s3_last <= s2_last;
      s3_val  <= (s2_t0 > TW'(ONE)) ? ONE : s2_t0[XW-1:0];
      s3_d1   <= d1_raw;
      s3_d2   <= d2_raw;
    end
  end

  // ---------------- stage 4: clamp to output ----------------
  always_comb begin
    d1_cl = (s3_d1 > D1_HI) ? D1_HI : ((s3_d1 < D1_LO) ? D1_LO : s3_d1);
    d2_cl = (s3_d2 > D2_HI) ? D2_HI : ((s3_d2 < D2_LO) ? D2_LO : s3_d2);
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      basis_index       <= s3_idx;
      basis_value       <= s3_val;
      first_derivative  <= d1_cl[D1W-1:0];
      second_derivative <= d2_cl[D2W-1:0];
      last              <= s3_last;
    end
  end

endmodule

FILE: hw/rtl/bernstein_basis_with_derivatives.sv
// Bernstein basis B(i,d)(xi) with first and second derivatives, i = 0..d.
// A point is popped from the queue, then d+1 power steps of the single (1-x)
// multiplier run, then indices i = 0..d are issued through stages 1 to 3 and
// the output register; the next point is popped only after index d. The
// two-entry queue lets two more points wait. Results leave one per cycle; no stall input.
// Reset (rst, synchronous): degree returns to 3, queue and pipeline empty.
module bernstein_basis_with_derivatives #(
  parameter int MAX_DEGREE = bbd_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bbd_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  // request channel
  input  logic                                             start,
  output logic                                             busy,
  input  logic [FRAC_BITS:0]                               xi,
  // degree register write channel
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [bbd_pkg::IDX_W-1:0]                        poly_degree,
  // result channel
  output logic                                             strobe,
  output logic [bbd_pkg::IDX_W-1:0]                        basis_index,
  output logic [FRAC_BITS:0]                               basis_value,
  output logic signed [FRAC_BITS+$clog2(MAX_DEGREE+1):0]   first_derivative,
  output logic signed [FRAC_BITS+$clog2(2*MAX_DEGREE*(MAX_DEGREE-1)+1):0]
                                                           second_derivative,
  output logic                                             last
);

  localparam int IW   = bbd_pkg::IDX_W;
  localparam int ITEM = IW + FRAC_BITS + 1;

  // Degree register. Writes must arrive only while idle, so each request
  // samples a stable value in the front end; the block does not enforce it.
  logic [IW-1:0] degree;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= bbd_pkg::DEGREE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      degree <= poly_degree;
    end
  end

  assign cfg_ready = 1'b1;

  // Front end: saturate xi to 1.0 and the degree to MAX_DEGREE, then
  // queue {degree, x}. busy is simply queue full.
  bbd_pkg::q_stat_t  q_stat;
  logic              q_push, q_pop;
  logic [ITEM-1:0]   q_wdata, q_rdata;

  bbd_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .start  (start),
    .busy   (busy),
    .xi     (xi),
    .degree (degree),
    .stat   (q_stat),
    .push   (q_push),
    .item   (q_wdata)
  );

  bbd_queue #(
    .W (ITEM)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back end: builds (1-x)^k into a shift line, then walks i = 0..d with
  // a running x^i. Terms of degree d, d-1, d-2 come out each cycle;
  // earlier terms are kept as history for the derivative differences.
  bbd_back #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .stat              (q_stat),
    .item              (q_rdata),
    .pop               (q_pop),
    .strobe            (strobe),
    .basis_index       (basis_index),
    .basis_value       (basis_value),
    .first_derivative  (first_derivative),
    .second_derivative (second_derivative),
    .last              (last)
  );

endmodule
